>>> src/tti_pkg.sv
// Shared constants, codes and types for the timed trajectory interpolator.
package tti_pkg;

	localparam int POINT_DEPTH = 64;
	localparam int PA_W = $clog2(POINT_DEPTH);
	localparam int CNT_W = $clog2(POINT_DEPTH + 1);
	localparam int NLANE = 6;
	localparam int TIME_W = 48;
	localparam int VAL_W = 32;
	localparam int FRAC_W = 17;
	localparam int FRAC_ONE = 65536;

	typedef enum logic [1:0] {
		KIND_VEL    = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic            we;
		logic            shift;
		logic            pend_we;
		logic            acc_we;
		logic [PA_W-1:0] raddr;
		logic [PA_W-1:0] waddr;
		logic            cap_left;
		logic            cap_mul;
		logic            cap_sum;
	} lane_ctl_t;

endpackage

>>> src/tti_if.sv
// Request channel interfaces: sample/load requests in, interpolated results out.
interface tti_in_if;
	import tti_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               kind;
	logic [TIME_W-1:0]        clock_time;
	logic [TIME_W-1:0]        point_offset;
	logic                     first_point;
	logic signed [VAL_W-1:0]  lin_x;
	logic signed [VAL_W-1:0]  lin_y;
	logic signed [VAL_W-1:0]  lin_z;
	logic signed [VAL_W-1:0]  ang_x;
	logic signed [VAL_W-1:0]  ang_y;
	logic signed [VAL_W-1:0]  ang_z;
	modport source (output valid, kind, clock_time, point_offset, first_point,
		lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, input ready);
	modport sink (input valid, kind, clock_time, point_offset, first_point,
		lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, output ready);
endinterface

interface tti_out_if;
	import tti_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     group;
	logic                     active;
	logic                     last;
	logic signed [VAL_W-1:0]  out_lin_x;
	logic signed [VAL_W-1:0]  out_lin_y;
	logic signed [VAL_W-1:0]  out_lin_z;
	logic signed [VAL_W-1:0]  out_ang_x;
	logic signed [VAL_W-1:0]  out_ang_y;
	logic signed [VAL_W-1:0]  out_ang_z;
	modport source (output valid, group, active, last, out_lin_x, out_lin_y,
		out_lin_z, out_ang_x, out_ang_y, out_ang_z, input ready);
	modport sink (input valid, group, active, last, out_lin_x, out_lin_y,
		out_lin_z, out_ang_x, out_ang_y, out_ang_z, output ready);
endinterface

>>> src/tti_lane.sv
// One value lane: velocity and acceleration column storage plus its interpolator.
module tti_lane import tti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] value,
	input  logic [FRAC_W-1:0]       frac,
	output logic signed [VAL_W-1:0] vel_res,
	output logic signed [VAL_W-1:0] acc_res
);

	logic signed [VAL_W-1:0] vel_mem [POINT_DEPTH];
	logic signed [VAL_W-1:0] acc_mem [POINT_DEPTH];
	logic signed [VAL_W-1:0] vel_rd_q, acc_rd_q;
	logic signed [VAL_W-1:0] pend_q, acc_in_q;
	logic signed [VAL_W-1:0] vel_left_q, acc_left_q;
	logic signed [VAL_W+FRAC_W+1:0] vel_prod_q, acc_prod_q;
	logic signed [VAL_W:0] vel_d, acc_d;
	logic signed [VAL_W+FRAC_W+1:0] vel_p, acc_p;

	assign vel_d = {vel_rd_q[VAL_W-1], vel_rd_q} - {vel_left_q[VAL_W-1], vel_left_q};
	assign acc_d = {acc_rd_q[VAL_W-1], acc_rd_q} - {acc_left_q[VAL_W-1], acc_left_q};
	assign vel_p = vel_d * $signed({1'b0, frac});
	assign acc_p = acc_d * $signed({1'b0, frac});

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			vel_mem[ctl.waddr] <= ctl.shift ? vel_rd_q : pend_q;
			acc_mem[ctl.waddr] <= ctl.shift ? acc_rd_q : acc_in_q;
		end
		vel_rd_q <= vel_mem[ctl.raddr];
		acc_rd_q <= acc_mem[ctl.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (ctl.pend_we) begin
			pend_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_we) acc_in_q <= value;
		if (ctl.cap_left) begin
			vel_left_q <= vel_rd_q;
			acc_left_q <= acc_rd_q;
		end
		if (ctl.cap_mul) begin
			vel_prod_q <= vel_p;
			acc_prod_q <= acc_p;
		end
		// floor of the scaled step keeps the result between the two points
		if (ctl.cap_sum) begin
			vel_res <= VAL_W'(vel_left_q + VAL_W'(vel_prod_q >>> 16));
			acc_res <= VAL_W'(acc_left_q + VAL_W'(acc_prod_q >>> 16));
		end
	end

endmodule

>>> src/tti_merge.sv
// Result stage: gathers the lane results and sends velocity then acceleration results.
module tti_merge import tti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    act,
	input  logic signed [VAL_W-1:0] vel [NLANE],
	input  logic signed [VAL_W-1:0] acc [NLANE],
	output logic                    free,
	tti_out_if.source               out_ch
);

	logic signed [VAL_W-1:0] vel_q [NLANE];
	logic signed [VAL_W-1:0] acc_q [NLANE];
	logic valid_q, grp_q, act_q;
	logic signed [VAL_W-1:0] sel [NLANE];

	assign free = !valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NLANE; i++) begin
				vel_q[i] <= act ? vel[i] : '0;
				acc_q[i] <= act ? acc[i] : '0;
			end
			act_q <= act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			grp_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			grp_q <= 1'b0;
		end else if (valid_q && out_ch.ready) begin
			if (grp_q) valid_q <= 1'b0;
			grp_q <= !grp_q;
		end
	end

	always_comb begin
		for (int i = 0; i < NLANE; i++) sel[i] = grp_q ? acc_q[i] : vel_q[i];
	end

	assign out_ch.valid = valid_q;
	assign out_ch.group = grp_q;
	assign out_ch.last = grp_q;
	assign out_ch.active = act_q;
	assign out_ch.out_lin_x = sel[0];
	assign out_ch.out_lin_y = sel[1];
	assign out_ch.out_lin_z = sel[2];
	assign out_ch.out_ang_x = sel[3];
	assign out_ch.out_ang_y = sel[4];
	assign out_ch.out_ang_z = sel[5];

endmodule

>>> src/timed_trajectory_interpolator.sv
// Top level of the timed trajectory interpolator: sequencer, time table and divider.
//
// One request is taken at a time. A velocity half is stored while idle. A commit walks
// the sorted time table (ST_SC_RD, ST_SC_CK) to find its slot, then moves each later
// point up one place (ST_SH_RD, ST_SH_WR) to open it and writes it (ST_WRITE). A sample
// walks the cursor (ST_WK_RD, ST_WK_CK), then runs the 17-step fraction divider and the
// six-lane interpolation; both results wait in the output stage, so the next request
// is taken while they drain. The time table and the lane stores each have one
// registered read port, which is why each step of both walks has a read state.
module timed_trajectory_interpolator import tti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tti_in_if.sink    in_ch,
	tti_out_if.source out_ch
);

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_SC_RD = 15'b000000000000010,
		ST_SC_CK = 15'b000000000000100,
		ST_SH_RD = 15'b000000000001000,
		ST_SH_WR = 15'b000000000010000,
		ST_WRITE = 15'b000000000100000,
		ST_WK_RD = 15'b000000001000000,
		ST_WK_CK = 15'b000000010000000,
		ST_LT_CK = 15'b000000100000000,
		ST_DIV   = 15'b000001000000000,
		ST_LN_L  = 15'b000010000000000,
		ST_LN_R  = 15'b000100000000000,
		ST_LN_M  = 15'b001000000000000,
		ST_LN_S  = 15'b010000000000000,
		ST_PUSH  = 15'b100000000000000
	} state_t;

	state_t state_q;
	logic [TIME_W-1:0] t_mem [POINT_DEPTH];
	logic [TIME_W-1:0] t_rd_q;
	logic [PA_W-1:0] t_raddr, t_waddr;
	logic [TIME_W-1:0] t_wdata;
	logic t_we;

	logic [CNT_W-1:0] count_q, cursor_q, pos_q, idx_q;
	logic [TIME_W-1:0] start_q, pend_time_q, elapsed_q, rt_q, den_q;
	logic [TIME_W:0] r_q;
	logic [FRAC_W-1:0] q_q;
	logic [4:0] step_q;
	logic act_q;
	logic accept, merge_free, merge_load;
	lane_ctl_t lctl;
	logic signed [VAL_W-1:0] in_val [NLANE];
	logic signed [VAL_W-1:0] vel_res [NLANE];
	logic signed [VAL_W-1:0] acc_res [NLANE];
	logic [TIME_W-1:0] lt, den, num;
	logic [CNT_W-1:0] li, idx_m1;
	logic [TIME_W:0] r_sub;
	logic r_ge;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign in_val[0] = in_ch.lin_x;
	assign in_val[1] = in_ch.lin_y;
	assign in_val[2] = in_ch.lin_z;
	assign in_val[3] = in_ch.ang_x;
	assign in_val[4] = in_ch.ang_y;
	assign in_val[5] = in_ch.ang_z;

	assign idx_m1 = idx_q - CNT_W'(1);
	assign li = (cursor_q != '0) ? cursor_q - CNT_W'(1) : cursor_q;
	assign lt = (cursor_q != '0) ? t_rd_q : '0;
	assign den = (rt_q >= lt) ? rt_q - lt : '0;
	assign num = (elapsed_q > lt) ? ((elapsed_q - lt > den) ? den : elapsed_q - lt) : '0;
	assign r_ge = (r_q >= {1'b0, den_q});
	assign r_sub = r_ge ? r_q - {1'b0, den_q} : r_q;

	always_comb begin
		t_raddr = pos_q[PA_W-1:0];
		t_we = 1'b0;
		t_waddr = pos_q[PA_W-1:0];
		t_wdata = pend_time_q;
		lctl = '0;
		lctl.raddr = idx_m1[PA_W-1:0];
		lctl.waddr = pos_q[PA_W-1:0];
		merge_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				lctl.pend_we = accept && (in_ch.kind == KIND_VEL);
				lctl.acc_we = accept && (in_ch.kind == KIND_COMMIT);
			end
			ST_SH_RD: t_raddr = idx_m1[PA_W-1:0];
			ST_SH_WR: begin
				t_we = 1'b1;
				t_waddr = idx_q[PA_W-1:0];
				t_wdata = t_rd_q;
				lctl.we = 1'b1;
				lctl.shift = 1'b1;
				lctl.waddr = idx_q[PA_W-1:0];
			end
			ST_WRITE: begin
				t_we = 1'b1;
				lctl.we = 1'b1;
			end
			ST_WK_RD: t_raddr = cursor_q[PA_W-1:0];
			ST_WK_CK: t_raddr = li[PA_W-1:0];
			ST_LN_L: lctl.raddr = li[PA_W-1:0];
			ST_LN_R: begin
				lctl.raddr = cursor_q[PA_W-1:0];
				lctl.cap_left = 1'b1;
			end
			ST_LN_M: lctl.cap_mul = 1'b1;
			ST_LN_S: lctl.cap_sum = 1'b1;
			ST_PUSH: merge_load = merge_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we) t_mem[t_waddr] <= t_wdata;
		t_rd_q <= t_mem[t_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cursor_q <= '0;
			start_q <= '0;
			pend_time_q <= '0;
			pos_q <= '0;
			idx_q <= '0;
			elapsed_q <= '0;
			rt_q <= '0;
			den_q <= '0;
			r_q <= '0;
			q_q <= '0;
			step_q <= '0;
			act_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					case (in_ch.kind)
						KIND_VEL: begin
							if (in_ch.first_point) begin
								count_q <= '0;
								cursor_q <= '0;
								start_q <= in_ch.clock_time;
							end
							pend_time_q <= in_ch.point_offset;
						end
						KIND_COMMIT: begin
							pos_q <= '0;
							state_q <= ST_SC_RD;
						end
						KIND_SAMPLE: begin
							elapsed_q <= (in_ch.clock_time >= start_q) ?
								in_ch.clock_time - start_q : '0;
							state_q <= ST_WK_RD;
						end
						default: ;
					endcase
				end
				ST_SC_RD: state_q <= ST_SC_CK;
				ST_SC_CK: begin
					if (pos_q < count_q && t_rd_q < pend_time_q) begin
						pos_q <= pos_q + CNT_W'(1);
						state_q <= ST_SC_RD;
					end else if (pos_q < count_q && t_rd_q == pend_time_q) begin
						state_q <= ST_WRITE;
					end else if (count_q >= CNT_W'(POINT_DEPTH)) begin
						// full table: drop the new point, cursor stays
						state_q <= ST_IDLE;
					end else begin
						idx_q <= count_q;
						count_q <= count_q + CNT_W'(1);
						state_q <= (count_q > pos_q) ? ST_SH_RD : ST_WRITE;
					end
				end
				ST_SH_RD: state_q <= ST_SH_WR;
				ST_SH_WR: begin
					idx_q <= idx_m1;
					state_q <= (idx_m1 > pos_q) ? ST_SH_RD : ST_WRITE;
				end
				ST_WRITE: begin
					cursor_q <= '0;
					state_q <= ST_IDLE;
				end
				ST_WK_RD: state_q <= ST_WK_CK;
				ST_WK_CK: begin
					if (cursor_q < count_q && elapsed_q > t_rd_q) begin
						cursor_q <= cursor_q + CNT_W'(1);
						state_q <= ST_WK_RD;
					end else begin
						act_q <= (cursor_q < count_q);
						rt_q <= t_rd_q;
						state_q <= (cursor_q < count_q) ? ST_LT_CK : ST_PUSH;
					end
				end
				ST_LT_CK: begin
					den_q <= den;
					r_q <= {1'b0, num};
					q_q <= '0;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (den_q == '0) begin
						q_q <= FRAC_W'(FRAC_ONE);
						state_q <= ST_LN_L;
					end else begin
						q_q <= {q_q[FRAC_W-2:0], r_ge};
						r_q <= {r_sub[TIME_W-1:0], 1'b0};
						step_q <= step_q + 5'd1;
						if (step_q == 5'(FRAC_W - 1)) state_q <= ST_LN_L;
					end
				end
				ST_LN_L: state_q <= ST_LN_R;
				ST_LN_R: state_q <= ST_LN_M;
				ST_LN_M: state_q <= ST_LN_S;
				ST_LN_S: state_q <= ST_PUSH;
				ST_PUSH: if (merge_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		tti_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.value  (in_val[g]),
			.frac   (q_q),
			.vel_res(vel_res[g]),
			.acc_res(acc_res[g])
		);
	end

	tti_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (merge_load),
		.act    (act_q),
		.vel    (vel_res),
		.acc    (acc_res),
		.free   (merge_free),
		.out_ch (out_ch)
	);

endmodule
